@@ hw/rtl/bde_pkg.sv @@
// Shared types and constants for the banked event deframer.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package bde_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned OFFSET_W = 31;
	localparam int unsigned FLAG_BIT = 31;
	localparam int unsigned HDR_W    = 2;

	localparam logic [HDR_W-1:0] HDR_OFFSET_POS = 2'd2;
	localparam logic [HDR_W-1:0] HDR_COUNT_POS  = 2'd3;
	localparam logic [HDR_W-1:0] PREFIX_LAST    = 2'd3;

	localparam int unsigned TDATA_W = 128;
	localparam int unsigned TUSER_W = 2;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
	} bde_beat_t;

	typedef struct packed {
		logic                event_valid;
		logic [WORD_W-1:0]   first_event_word;
		logic [WORD_W-1:0]   second_event_word;
		logic [WORD_W-1:0]   bank_id;
		logic [OFFSET_W-1:0] tof_offset;
		logic                tof_corrected;
		logic                packet_end;
		logic                packet_short;
	} bde_result_t;

endpackage

`default_nettype wire

@@ hw/rtl/banked_event_deframer.sv @@
// Banked event deframer top level: input register, parser, result register.
// Depends on bde_pkg, bde_in_reg, bde_parser and bde_out_reg.
//
// Usage:
//   s_axis carries the packet payload, one 32-bit word per beat, with tlast
//   on the final word of each packet. The first four words are skipped as
//   prefix; source headers, bank headers and two-word events follow.
//   m_axis carries one beat per completed event and one on the packet's last
//   word (both merged into one beat when they coincide). tlast marks packet
//   end; tuser flags event valid and a packet too short for its prefix.
//   Non-event beats carry all-zero tdata.
//   Throughput: one input beat per cycle while the result register can take
//   results; the parse update between the input and result registers is
//   combinational, and each result passes through both registers.
//   When the receiver stalls, the result register holds its beat; beats
//   that make no result keep flowing, and input stalls only once a new
//   result has nowhere to go.
//   Reset (arst_n low) empties both registers and returns the parser to the
//   packet prefix; no clearing pass is needed.
`default_nettype none

module banked_event_deframer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [bde_pkg::WORD_W-1:0]    s_axis_tdata,  // payload_word
	input  wire logic                          s_axis_tlast,  // last_word
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// first_event_word, second_event_word, bank_id, tof_offset, tof_corrected
	output logic [bde_pkg::TDATA_W-1:0]        m_axis_tdata,
	output logic                               m_axis_tlast,  // packet_end
	output logic [bde_pkg::TUSER_W-1:0]        m_axis_tuser   // event_valid, packet_short
);
	import bde_pkg::*;

	bde_beat_t   in_beat, s1_beat;
	logic        s1_valid, s1_ready;
	bde_result_t pr_res, out_res;
	logic        pr_valid, pr_ready;

	assign in_beat.word = s_axis_tdata;
	assign in_beat.last = s_axis_tlast;

	bde_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_beat   (in_beat),
		.out_valid (s1_valid),
		.out_ready (s1_ready),
		.out_beat  (s1_beat)
	);

	bde_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s1_valid),
		.in_ready  (s1_ready),
		.in_beat   (s1_beat),
		.res_valid (pr_valid),
		.res_ready (pr_ready),
		.res       (pr_res)
	);

	bde_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pr_valid),
		.in_ready  (pr_ready),
		.in_res    (pr_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.tof_corrected, out_res.tof_offset, out_res.bank_id,
		out_res.second_event_word, out_res.first_event_word};
	assign m_axis_tlast = out_res.packet_end;
	assign m_axis_tuser = {out_res.packet_short, out_res.event_valid};

endmodule

`default_nettype wire

@@ hw/rtl/bde_in_reg.sv @@
// Input register stage: holds one accepted payload beat for the parser.
// Depends on bde_pkg.
`default_nettype none

module bde_in_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bde_pkg::bde_beat_t in_beat,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bde_pkg::bde_beat_t     out_beat
);
	import bde_pkg::*;

	logic      valid_s1;
	bde_beat_t beat_s1;

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_beat  = beat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_beat;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bde_parser.sv @@
// Parse state machine: walks prefix, source headers, banks and events,
// one word per beat. Depends on bde_pkg.
`default_nettype none

module bde_parser (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire bde_pkg::bde_beat_t in_beat,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output bde_pkg::bde_result_t    res
);
	import bde_pkg::*;

	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_SRC_HDR,
		PH_BANK_ID,
		PH_BANK_CNT,
		PH_EV_FIRST,
		PH_EV_SECOND
	} phase_t;

	phase_t              phase_q, phase_d;
	logic [HDR_W-1:0]    hdr_q, hdr_d;
	logic [WORD_W-1:0]   banks_q, banks_d;
	logic [WORD_W-1:0]   events_q, events_d;
	logic [WORD_W-1:0]   bank_q, bank_d;
	logic [OFFSET_W-1:0] offset_q, offset_d;
	logic                flag_q, flag_d;
	logic [WORD_W-1:0]   held_q;
	logic [WORD_W-1:0]   banks_dec, events_dec;
	logic                emit, fire, ev, short_pkt;
	logic [WORD_W-1:0]   w;
	logic                last;

	assign w    = in_beat.word;
	assign last = in_beat.last;

	assign emit     = (phase_q == PH_EV_SECOND) || last;
	assign in_ready = !emit || res_ready;
	assign fire     = in_valid && in_ready;

	assign banks_dec  = banks_q - {{(WORD_W-1){1'b0}}, (banks_q != '0)};
	assign events_dec = events_q - {{(WORD_W-1){1'b0}}, (events_q != '0)};

	always_comb begin
		phase_d   = phase_q;
		hdr_d     = hdr_q;
		banks_d   = banks_q;
		events_d  = events_q;
		bank_d    = bank_q;
		offset_d  = offset_q;
		flag_d    = flag_q;
		ev        = 1'b0;
		short_pkt = 1'b0;
		case (phase_q)
			PH_SRC_HDR: begin
				if (hdr_q == HDR_OFFSET_POS) begin
					offset_d = w[OFFSET_W-1:0];
					flag_d   = w[FLAG_BIT];
				end
				if (hdr_q == HDR_COUNT_POS) begin
					banks_d = w;
					hdr_d   = '0;
					if (w != '0) begin
						phase_d = PH_BANK_ID;
					end
				end else begin
					hdr_d = hdr_q + 2'd1;
				end
			end
			PH_BANK_ID: begin
				bank_d  = w;
				phase_d = PH_BANK_CNT;
			end
			PH_BANK_CNT: begin
				events_d = w;
				if (w == '0) begin
					banks_d = banks_dec;
					if (banks_dec == '0) begin
						phase_d = PH_SRC_HDR;
						hdr_d   = '0;
					end else begin
						phase_d = PH_BANK_ID;
					end
				end else begin
					phase_d = PH_EV_FIRST;
				end
			end
			PH_EV_FIRST: begin
				phase_d = PH_EV_SECOND;
			end
			PH_EV_SECOND: begin
				ev       = 1'b1;
				events_d = events_dec;
				if (events_dec == '0) begin
					banks_d = banks_dec;
					if (banks_dec == '0) begin
						phase_d = PH_SRC_HDR;
						hdr_d   = '0;
					end else begin
						phase_d = PH_BANK_ID;
					end
				end else begin
					phase_d = PH_EV_FIRST;
				end
			end
			default: begin
				if (hdr_q == PREFIX_LAST) begin
					hdr_d   = '0;
					phase_d = PH_SRC_HDR;
				end else begin
					short_pkt = last;
					hdr_d     = hdr_q + 2'd1;
				end
			end
		endcase
		if (last) begin
			phase_d  = PH_PREFIX;
			hdr_d    = '0;
			banks_d  = '0;
			events_d = '0;
			bank_d   = '0;
			offset_d = '0;
			flag_d   = 1'b0;
		end
	end

	always_comb begin
		res = '0;
		res.event_valid  = ev;
		res.packet_end   = last;
		res.packet_short = short_pkt;
		if (ev) begin
			res.first_event_word  = held_q;
			res.second_event_word = w;
			res.bank_id           = bank_q;
			res.tof_offset        = offset_q;
			res.tof_corrected     = flag_q;
		end
	end

	assign res_valid = fire && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PREFIX;
			hdr_q    <= '0;
			banks_q  <= '0;
			events_q <= '0;
			bank_q   <= '0;
			offset_q <= '0;
			flag_q   <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			hdr_q    <= hdr_d;
			banks_q  <= banks_d;
			events_q <= events_d;
			bank_q   <= bank_d;
			offset_q <= offset_d;
			flag_q   <= flag_d;
		end
	end

	// first event word, only read after it is written in the same event
	always_ff @(posedge clk) begin
		if (fire && (phase_q == PH_EV_FIRST)) begin
			held_q <= w;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bde_out_reg.sv @@
// Result register: holds one result beat until the receiver takes it.
// Depends on bde_pkg.
`default_nettype none

module bde_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire bde_pkg::bde_result_t in_res,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output bde_pkg::bde_result_t      out_res
);
	import bde_pkg::*;

	logic        valid_q;
	bde_result_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			res_q <= in_res;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bde_checker.sv @@
// Port-level checker for the banked event deframer, bound to the top level.
// Depends on bde_pkg and banked_event_deframer.
`default_nettype none

module bde_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [bde_pkg::TDATA_W-1:0]   m_axis_tdata,
	input wire logic                          m_axis_tlast,
	input wire logic [bde_pkg::TUSER_W-1:0]   m_axis_tuser
);
	import bde_pkg::*;

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
			&& $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	// a beat without an event is only a packet end
	a_noev_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("empty result beat without packet end");

	// short packets end inside the prefix, so carry no event
	a_short: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
		else $error("short flag outside a bare packet end");

	a_noev_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
		else $error("packet end beat carries nonzero data");

endmodule

bind banked_event_deframer bde_checker u_bde_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
